[design/sbvl_pkg.sv]
`default_nettype none

package sbvl_pkg;

  localparam int unsigned MaxJoints     = 16;
  localparam int unsigned MaxDims       = 4;
  localparam int unsigned CoordBits     = 20;
  localparam int unsigned LossBits      = 63;
  localparam int unsigned SumBits       = 64;
  localparam int unsigned CountBits     = 32;
  localparam int unsigned CfgDimsBits   = 3;
  localparam int unsigned CfgJointsBits = 5;
  localparam int unsigned ApbAddrBits   = 3;
  localparam int unsigned ApbDataBits   = 32;

  // register index, taken from paddr[2]
  localparam logic RegCoordDims  = 1'b0;
  localparam logic RegJointCount = 1'b1;

  localparam logic [CfgDimsBits-1:0]   DimsReset   = 3'd3;
  localparam logic [CfgJointsBits-1:0] JointsReset = 5'd16;

  // parent of each joint; never larger than the joint itself
  localparam logic [3:0] ParentOf [16] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd0, 4'd4, 4'd5, 4'd0,
    4'd7, 4'd8, 4'd8, 4'd10, 4'd11, 4'd8, 4'd13, 4'd14
  };

  typedef struct packed {
    logic capture;
    logic diff_en;
    logic sq_en;
    logic acc_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } sbvl_cmd_t;

  typedef struct packed {
    logic batch_end;
    logic div_last;
  } sbvl_stat_t;

endpackage

`default_nettype wire

[design/sbvl_in_if.sv]
`default_nettype none

interface sbvl_in_if
  import sbvl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBits
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pred_coord;
  logic signed [COORD_BITS-1:0] target_coord;
  logic                         batch_end;

  modport source (output valid, pred_coord, target_coord, batch_end, input ready);
  modport sink   (input valid, pred_coord, target_coord, batch_end, output ready);

endinterface

`default_nettype wire

[design/sbvl_out_if.sv]
`default_nettype none

interface sbvl_out_if
  import sbvl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBits
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] bone_diff;
  logic                         loss_valid;
  logic [LossBits-1:0]          loss;

  modport source (output valid, bone_diff, loss_valid, loss, input ready);
  modport sink   (input valid, bone_diff, loss_valid, loss, output ready);

endinterface

`default_nettype wire

[design/sbvl_ctrl.sv]
`default_nettype none

module sbvl_ctrl
  import sbvl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  input  wire sbvl_stat_t stat_i,
  output sbvl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_SQR;
      end
      S_SQR: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (stat_i.batch_end) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[design/sbvl_dpath.sv]
`default_nettype none

module sbvl_dpath
  import sbvl_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = MaxJoints,
  parameter int unsigned MAX_DIMS   = MaxDims,
  parameter int unsigned COORD_BITS = CoordBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sbvl_cmd_t                    cmd_i,
  output sbvl_stat_t                        stat_o,
  input  wire logic signed [COORD_BITS-1:0] pred_coord_i,
  input  wire logic signed [COORD_BITS-1:0] target_coord_i,
  input  wire logic                         batch_end_i,
  input  wire logic [CfgDimsBits-1:0]       dims_i,
  input  wire logic [CfgJointsBits-1:0]     joints_i,
  output logic signed [COORD_BITS+1:0]      bone_diff_o,
  output logic                              loss_valid_o,
  output logic [LossBits-1:0]               loss_o
);

  localparam int unsigned Depth   = MAX_JOINTS * MAX_DIMS;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned JointW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int unsigned DimW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DiffW   = COORD_BITS + 2;
  localparam int unsigned SqW     = 2 * DiffW;
  localparam int unsigned AccW    = ((SqW > SumBits) ? SqW : SumBits) + 1;
  localparam int unsigned DivW    = CountBits + 1;
  localparam int unsigned DivCntW = $clog2(SumBits);

  // pose store: {pred, target} per joint coordinate
  logic [2*COORD_BITS-1:0] mem_q [Depth];
  logic [2*COORD_BITS-1:0] rd_q;

  logic [JointW-1:0]           joint_idx_q, joint_idx_d;
  logic [DimW-1:0]             coord_idx_q, coord_idx_d;
  logic [SumBits-1:0]          sum_q, sum_d;
  logic [CountBits-1:0]        count_q, count_d;
  logic                        end_q;
  logic [DivCntW-1:0]          div_cnt_q;

  logic signed [COORD_BITS-1:0] pc_q, tc_q;
  logic                         root_q;
  logic signed [DiffW-1:0]      diff_q;
  logic signed [SqW-1:0]        sq_q;
  logic [SumBits-1:0]           dq_q;
  logic [DivW-1:0]              rem_q;
  logic [DivW-1:0]              divisor_q;

  logic [AddrW-1:0]  waddr, raddr;
  logic [3:0]        parent_raw;
  logic [JointW-1:0] parent;

  always_comb begin
    parent_raw = ParentOf[4'(joint_idx_q)];
    if (5'(parent_raw) >= 5'(MAX_JOINTS)) begin
      parent = joint_idx_q;
    end else begin
      parent = JointW'(parent_raw);
    end
    waddr = AddrW'(32'(joint_idx_q) * 32'(MAX_DIMS) + 32'(coord_idx_q));
    raddr = AddrW'(32'(parent) * 32'(MAX_DIMS) + 32'(coord_idx_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mem_q[waddr] <= {pred_coord_i, target_coord_i};
      rd_q         <= mem_q[raddr];
    end
  end

  // difference of bones; the root's bone is zero in both poses
  logic signed [COORD_BITS-1:0] rp, rt;
  logic signed [DiffW-1:0]      diff_c;

  assign rp     = $signed(rd_q[2*COORD_BITS-1:COORD_BITS]);
  assign rt     = $signed(rd_q[COORD_BITS-1:0]);
  assign diff_c = (DiffW'(rp) - DiffW'(pc_q)) - (DiffW'(rt) - DiffW'(tc_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pc_q   <= pred_coord_i;
      tc_q   <= target_coord_i;
      root_q <= (parent == joint_idx_q);
    end
    if (cmd_i.diff_en) begin
      diff_q <= root_q ? '0 : diff_c;
    end
    if (cmd_i.sq_en) begin
      sq_q <= SqW'(diff_q) * SqW'(diff_q);
    end
  end

  // saturating accumulate and index bookkeeping
  logic [AccW-1:0]      acc_ext;
  logic [SumBits-1:0]   sum_sat;
  logic [CountBits-1:0] count_inc;
  logic                 last_coord, last_joint;

  always_comb begin
    acc_ext    = AccW'(sum_q) + AccW'($unsigned(sq_q));
    sum_sat    = (acc_ext[AccW-1:SumBits] != '0) ? '1 : acc_ext[SumBits-1:0];
    count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
    last_coord = (8'(coord_idx_q) + 8'd1) >= 8'(dims_i);
    last_joint = (8'(joint_idx_q) + 8'd1) >= 8'(joints_i);

    joint_idx_d = joint_idx_q;
    coord_idx_d = coord_idx_q;
    sum_d       = sum_q;
    count_d     = count_q;
    if (cmd_i.acc_en) begin
      if (end_q) begin
        joint_idx_d = '0;
        coord_idx_d = '0;
        sum_d       = '0;
        count_d     = '0;
      end else begin
        sum_d = sum_sat;
        if (last_coord) begin
          coord_idx_d = '0;
          if (last_joint) begin
            joint_idx_d = '0;
            count_d     = count_inc;
          end else begin
            joint_idx_d = JointW'(32'(joint_idx_q) + 32'd1);
          end
        end else begin
          coord_idx_d = DimW'(32'(coord_idx_q) + 32'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_idx_q <= '0;
      coord_idx_q <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      end_q       <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      joint_idx_q <= joint_idx_d;
      coord_idx_q <= coord_idx_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      if (cmd_i.capture) begin
        end_q <= batch_end_i;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts into dq_q
  logic [DivW:0]    rem_shift;
  logic             rem_ge;
  logic [DivW-1:0]  rem_next;

  always_comb begin
    rem_shift = {rem_q, dq_q[SumBits-1]};
    rem_ge    = rem_shift >= {1'b0, divisor_q};
    rem_next  = rem_ge ? DivW'(rem_shift - {1'b0, divisor_q}) : rem_shift[DivW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q      <= sum_sat;
      rem_q     <= '0;
      divisor_q <= {count_inc, 1'b0};
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[SumBits-2:0], rem_ge};
      rem_q <= rem_next;
    end
  end

  assign stat_o.batch_end = end_q;
  assign stat_o.div_last  = (div_cnt_q == DivCntW'(SumBits - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bone_diff_o  <= diff_q;
      loss_valid_o <= end_q;
      loss_o       <= end_q ? dq_q[LossBits-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

[design/skeleton_bone_vector_loss.sv]
// A result passes through the difference, square and accumulate states into the
// output register; a batch-end transaction also runs the serial divider first.
// One transaction at a time: intake reopens only once the output register is loaded.
// Reset (rst_ni, asynchronous, active low) clears indices, sum, sample count and
// handshake state, and sets coord_dims to 3 and joint_count to 16; the pose
// store holds no valid data until written.
`default_nettype none

module skeleton_bone_vector_loss
  import sbvl_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = MaxJoints,
  parameter int unsigned MAX_DIMS   = MaxDims,
  parameter int unsigned COORD_BITS = CoordBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  sbvl_in_if.sink                     in_i,
  sbvl_out_if.source                  out_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic [ApbDataBits-1:0]      prdata,
  output logic                        pready
);

  logic [CfgDimsBits-1:0]   cfg_dims_q;
  logic [CfgJointsBits-1:0] cfg_joints_q;
  logic [CfgDimsBits-1:0]   dims_eff;
  logic [CfgJointsBits-1:0] joints_eff;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dims_q   <= DimsReset;
      cfg_joints_q <= JointsReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegCoordDims) begin
        cfg_dims_q <= pwdata[CfgDimsBits-1:0];
      end else begin
        cfg_joints_q <= pwdata[CfgJointsBits-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegJointCount) ? ApbDataBits'(cfg_joints_q)
                                              : ApbDataBits'(cfg_dims_q);

  // out-of-range settings clamp into 1..MAX
  always_comb begin
    if (cfg_dims_q == '0) begin
      dims_eff = CfgDimsBits'(1);
    end else if (32'(cfg_dims_q) > MAX_DIMS) begin
      dims_eff = CfgDimsBits'(MAX_DIMS);
    end else begin
      dims_eff = cfg_dims_q;
    end
    if (cfg_joints_q == '0) begin
      joints_eff = CfgJointsBits'(1);
    end else if (32'(cfg_joints_q) > MAX_JOINTS) begin
      joints_eff = CfgJointsBits'(MAX_JOINTS);
    end else begin
      joints_eff = cfg_joints_q;
    end
  end

  sbvl_cmd_t  cmd;
  sbvl_stat_t stat;

  sbvl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sbvl_dpath #(
    .MAX_JOINTS (MAX_JOINTS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pred_coord_i   (in_i.pred_coord),
    .target_coord_i (in_i.target_coord),
    .batch_end_i    (in_i.batch_end),
    .dims_i         (dims_eff),
    .joints_i       (joints_eff),
    .bone_diff_o    (out_o.bone_diff),
    .loss_valid_o   (out_o.loss_valid),
    .loss_o         (out_o.loss)
  );

endmodule

`default_nettype wire

[design/sbvl_checker.sv]
`default_nettype none

module sbvl_checker
  import sbvl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBits
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_loss_valid,
  input wire logic [LossBits-1:0]   out_loss,
  input wire logic [COORD_BITS+1:0] out_bone_diff
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // one transaction in flight: intake closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !in_ready)
    else $error("input accepted again while busy");

  // the result goes through the datapath registers before out_valid can rise
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !$rose(out_valid))
    else $error("result appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid && !out_loss_valid) |-> (out_loss == '0))
    else $error("loss nonzero without loss_valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid && !out_ready) |=> $stable(out_bone_diff))
    else $error("result changed while stalled");

endmodule

bind skeleton_bone_vector_loss sbvl_checker #(
  .COORD_BITS (COORD_BITS)
) u_sbvl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_loss_valid (out_o.loss_valid),
  .out_loss       (out_o.loss),
  .out_bone_diff  (out_o.bone_diff)
);

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
  import sbvl_pkg::*;

  localparam int unsigned TargetItems = 450;
  localparam int unsigned CalmItems   = 60;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 100;

  localparam logic signed [CoordBits-1:0] CoordMax = 20'sh7FFFF;
  localparam logic signed [CoordBits-1:0] CoordMin = 20'sh80000;

  typedef struct packed {
    logic signed [CoordBits-1:0] pred;
    logic signed [CoordBits-1:0] target;
    logic                        batch_end;
  } coord_item_t;

  typedef struct packed {
    logic signed [CoordBits+1:0] bone_diff;
    logic                        loss_valid;
    logic [LossBits-1:0]         loss;
  } bone_result_t;

  // Tracks the pose store, indices and running sums; one expected result per coordinate.
  class bone_loss_board;
    bone_result_t             pending_results[$];
    int unsigned              mismatches;
    int unsigned              loss_checks;
    logic [CfgDimsBits-1:0]   dims_reg;
    logic [CfgJointsBits-1:0] joints_reg;
    longint                   pred_store[MaxJoints*MaxDims];
    longint                   target_store[MaxJoints*MaxDims];
    logic [3:0]               joint_idx;
    logic [1:0]               coord_idx;
    logic [SumBits-1:0]       square_sum;
    logic [CountBits-1:0]     sample_count;

    function new();
      mismatches   = 0;
      loss_checks  = 0;
      dims_reg     = DimsReset;
      joints_reg   = JointsReset;
      joint_idx    = '0;
      coord_idx    = '0;
      square_sum   = '0;
      sample_count = '0;
      foreach (pred_store[i]) begin
        pred_store[i]   = 0;
        target_store[i] = 0;
      end
    endfunction

    function void write_reg(logic idx, logic [ApbDataBits-1:0] value);
      if (idx == RegCoordDims) begin
        dims_reg = value[CfgDimsBits-1:0];
      end else begin
        joints_reg = value[CfgJointsBits-1:0];
      end
    endfunction

    function void note_coord(coord_item_t item);
      int unsigned        dims, joints, j, d, p;
      longint             pc, tc, bp, bt, diff;
      logic [SumBits-1:0] ad, sq, n, quot;
      bone_result_t       res;
      dims   = (dims_reg == 0) ? 1 : ((dims_reg > MaxDims) ? MaxDims : dims_reg);
      joints = (joints_reg == 0) ? 1 : ((joints_reg > MaxJoints) ? MaxJoints : joints_reg);
      j  = joint_idx;
      d  = coord_idx;
      pc = item.pred;
      tc = item.target;
      pred_store[j*MaxDims + d]   = pc;
      target_store[j*MaxDims + d] = tc;
      p    = ParentOf[j];
      bp   = pred_store[p*MaxDims + d] - pc;
      bt   = target_store[p*MaxDims + d] - tc;
      diff = bp - bt;
      ad   = (diff < 0) ? -diff : diff;
      sq   = (ad > 64'hFFFF_FFFF) ? '1 : ad * ad;
      square_sum = (square_sum > ~sq) ? '1 : square_sum + sq;

      res.bone_diff  = diff[CoordBits+1:0];
      res.loss_valid = item.batch_end;
      res.loss       = '0;
      if (item.batch_end) begin
        // the open sample counts even when cut short
        n = {32'b0, sample_count} + 64'd1;
        if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
        quot         = square_sum / (n << 1);
        res.loss     = quot[LossBits-1:0];
        joint_idx    = '0;
        coord_idx    = '0;
        square_sum   = '0;
        sample_count = '0;
      end else if (coord_idx + 1 >= dims) begin
        coord_idx = '0;
        if (joint_idx + 1 >= joints) begin
          joint_idx = '0;
          if (sample_count != '1) sample_count = sample_count + 1;
        end else begin
          joint_idx = joint_idx + 1;
        end
      end else begin
        coord_idx = coord_idx + 1;
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(bone_result_t got);
      bone_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result bone_diff=%0d loss_valid=%0b loss=%0d",
                 $time, got.bone_diff, got.loss_valid, got.loss);
      end else begin
        want = pending_results.pop_front();
        if (want.loss_valid) loss_checks++;
        if (got.bone_diff !== want.bone_diff) begin
          mismatches++;
          $display("%0t: bone_diff expected %0d actual %0d",
                   $time, want.bone_diff, got.bone_diff);
        end
        if (got.loss_valid !== want.loss_valid) begin
          mismatches++;
          $display("%0t: loss_valid expected %0b actual %0b",
                   $time, want.loss_valid, got.loss_valid);
        end
        if (got.loss !== want.loss) begin
          mismatches++;
          $display("%0t: loss expected %0d actual %0d", $time, want.loss, got.loss);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  sbvl_in_if  in_if ();
  sbvl_out_if out_if ();

  skeleton_bone_vector_loss DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bone_loss_board board = new();

  int unsigned items_sent;
  int unsigned batches_sent;
  int unsigned settings_used;
  int unsigned idle_cycles;
  logic        calm_tail;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stall bursts until the tail of the run
  initial begin : sink_ready
    int unsigned stall_len;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        stall_len = $urandom_range(1, 3);
        out_if.ready = 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result('{bone_diff: out_if.bone_diff, loss_valid: out_if.loss_valid,
                           loss: out_if.loss});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, board.pending_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [CoordBits-1:0] rand_coord();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 7))
      0:       rand_coord = CoordMin;
      1:       rand_coord = CoordMax;
      2:       rand_coord = CoordBits'(signed'($urandom_range(0, 63)) - 32);
      default: rand_coord = raw[CoordBits-1:0];
    endcase
  endfunction

  task automatic drive_coord(logic signed [CoordBits-1:0] pred,
                             logic signed [CoordBits-1:0] target, logic last);
    int unsigned gap;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        = 1'b1;
    in_if.pred_coord   = pred;
    in_if.target_coord = target;
    in_if.batch_end    = last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_coord('{pred: pred, target: target, batch_end: last});
    items_sent++;
    if (last) batches_sent++;
    if (items_sent >= TargetItems - CalmItems) calm_tail = 1'b1;
  endtask

  // sender holds off until every pending result is back
  task automatic settle();
    @(negedge clk_i);
    in_if.valid     = 1'b0;
    in_if.batch_end = 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(logic idx, logic [ApbDataBits-1:0] value);
    logic [ApbDataBits-1:0] want;
    logic [ApbDataBits-1:0] got;
    want = (idx == RegCoordDims) ? (value & 32'h7) : (value & 32'h1F);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, value);
    // read back
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      board.mismatches++;
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, want, got);
    end
  endtask

  // a batch that would run past the item budget is closed early, inside its sample
  task automatic send_batch(int unsigned dims_raw, int unsigned joints_raw,
                            int unsigned samples, logic cut);
    int unsigned per_sample;
    int unsigned total;
    int unsigned room;
    per_sample = ((dims_raw == 0) ? 1 : ((dims_raw > MaxDims) ? MaxDims : dims_raw)) *
                 ((joints_raw == 0) ? 1 : ((joints_raw > MaxJoints) ? MaxJoints : joints_raw));
    total = samples * per_sample;
    if (cut) total = total - per_sample + $urandom_range(1, per_sample);
    room = (items_sent < TargetItems) ? TargetItems - items_sent : 1;
    if (total > room) total = room;
    for (int unsigned k = 0; k < total; k++) begin
      drive_coord(rand_coord(), rand_coord(), k == total - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned forced_dims[6];
    int unsigned forced_joints[6];
    int unsigned dims_sel;
    int unsigned joints_sel;
    int unsigned n_batches;
    forced_dims   = '{1, 4, 1, 4, 0, 6};
    forced_joints = '{1, 16, 16, 1, 31, 17};
    rst_ni             = 1'b0;
    calm_tail          = 1'b0;
    items_sent         = 0;
    batches_sent       = 0;
    settings_used      = 0;
    in_if.valid        = 1'b0;
    in_if.pred_coord   = '0;
    in_if.target_coord = '0;
    in_if.batch_end    = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // largest bone differences of both signs, root joint bone is zero
    program_reg(RegCoordDims, 1);
    program_reg(RegJointCount, 2);
    drive_coord(CoordMin, CoordMax, 1'b0);
    drive_coord(CoordMax, CoordMin, 1'b0);
    drive_coord(CoordMax, CoordMin, 1'b0);
    drive_coord(CoordMin, CoordMax, 1'b1);
    settle();

    // batch closed inside a sample, and a batch of one transaction
    program_reg(RegCoordDims, 2);
    program_reg(RegJointCount, 3);
    drive_coord(20'sh12345, -20'sh00400, 1'b0);
    drive_coord(-20'sh3FFFF, 20'sh00001, 1'b0);
    drive_coord(CoordMax, CoordMax, 1'b1);
    drive_coord(20'sh00000, 20'sh00000, 1'b1);
    settle();

    // out-of-range register values clamp
    program_reg(RegCoordDims, 0);
    program_reg(RegJointCount, 0);
    repeat (2) drive_coord(rand_coord(), rand_coord(), 1'b0);
    drive_coord(rand_coord(), rand_coord(), 1'b1);
    settle();
    program_reg(RegCoordDims, 7);
    repeat (3) drive_coord(rand_coord(), rand_coord(), 1'b0);
    drive_coord(rand_coord(), rand_coord(), 1'b1);
    settle();

    // shrink both registers in the middle of a sample
    program_reg(RegCoordDims, 4);
    program_reg(RegJointCount, 16);
    repeat (6) drive_coord(rand_coord(), rand_coord(), 1'b0);
    settle();
    program_reg(RegCoordDims, 1);
    repeat (2) drive_coord(rand_coord(), rand_coord(), 1'b0);
    settle();
    program_reg(RegJointCount, 1);
    drive_coord(rand_coord(), rand_coord(), 1'b0);
    drive_coord(rand_coord(), rand_coord(), 1'b1);
    settle();
    settings_used = 7;

    // random batches; settings change only once a batch has closed
    for (int unsigned ph = 0; items_sent < TargetItems; ph++) begin
      if (ph < 6) begin
        dims_sel   = forced_dims[ph];
        joints_sel = forced_joints[ph];
      end else begin
        dims_sel   = $urandom_range(0, 7);
        joints_sel = $urandom_range(0, 31);
      end
      program_reg(RegCoordDims, dims_sel);
      program_reg(RegJointCount, joints_sel);
      settings_used++;
      n_batches = $urandom_range(1, 2);
      repeat (n_batches) begin
        if (items_sent < TargetItems) begin
          send_batch(dims_sel, joints_sel, $urandom_range(1, 3), $urandom_range(0, 3) == 0);
        end
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending_results.size() != 0) begin
      board.mismatches++;
      $display("%0t: %0d results never arrived", $time, board.pending_results.size());
    end
    $display("Sent %0d coordinates in %0d batches across %0d register settings;",
             items_sent, batches_sent, settings_used);
    $display("checked %0d batch losses, %0d mismatches", board.loss_checks, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
